// ===== hw/rtl/cvr_pkg.sv =====
`default_nettype none
package cvr_pkg;

  localparam int CompW  = 32;            // Q16.16 component width
  localparam int CoefW  = 17;            // Q1.16 coefficient, 65536 = 1.0
  localparam int RemW   = 64;            // divisor / remainder width (n.n)
  localparam int QBits  = 34;            // quotient bits, |vn| < 2^33
  localparam int NumW   = 96;            // |d| * |n_i| width
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] IdxRestitution = 2'd0;
  localparam logic [CfgIdxW-1:0] IdxFriction    = 2'd1;

  localparam logic signed [17:0] QOne   = 18'sd65536;
  localparam logic signed [38:0] OutMax = 39'sd2147483647;
  localparam logic signed [38:0] OutMin = -39'sd2147483648;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic            qbit;
  } div_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cvr_div_step.sv =====
`default_nettype none
module cvr_div_step (
  input  wire logic [cvr_pkg::RemW-1:0] rem,
  input  wire logic [cvr_pkg::RemW-1:0] den,
  input  wire logic                     bit_in,
  output cvr_pkg::div_res_t             res
);
  import cvr_pkg::*;

  logic [RemW:0] shifted;
  logic [RemW:0] diff;

  // one restoring step; rem < den on entry keeps the result below den
  always_comb begin
    shifted = {rem, bit_in};
    diff    = shifted - {1'b0, den};
    if (shifted >= {1'b0, den}) begin
      res.rem  = diff[RemW-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = shifted[RemW-1:0];
      res.qbit = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/collision_velocity_response.sv =====
// Data path: 41 register stages from input transfer to result valid (4 front stages
// for the dot products and the wide product, 34 divider stages with one quotient bit
// each, 3 back stages: normal part, coefficient products, blend with rounding, clamp).
// Throughput: one item per cycle; the whole pipeline holds only while a result waits
// and out_ready is low.
// Reset (rst, synchronous): clears all stage valid bits and both coefficients to 0.
`default_nettype none
module collision_velocity_response (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cvr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [cvr_pkg::CoefW-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [cvr_pkg::CompW-1:0] vel_x,
  input  wire logic signed [cvr_pkg::CompW-1:0] vel_y,
  input  wire logic signed [cvr_pkg::CompW-1:0] vel_z,
  input  wire logic signed [cvr_pkg::CompW-1:0] norm_x,
  input  wire logic signed [cvr_pkg::CompW-1:0] norm_y,
  input  wire logic signed [cvr_pkg::CompW-1:0] norm_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [cvr_pkg::CompW-1:0]   out_x,
  output logic signed [cvr_pkg::CompW-1:0]   out_y,
  output logic signed [cvr_pkg::CompW-1:0]   out_z,
  output logic                               zero_normal,
  output logic                               saturated
);
  import cvr_pkg::*;

  localparam int NStages = 4 + QBits + 3;

  // coefficients; write only while the pipeline is empty, the block does not enforce it
  logic [CoefW-1:0] restitution;
  logic [CoefW-1:0] friction;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= '0;
      friction    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        IdxRestitution: restitution <= cfg_data;
        IdxFriction:    friction    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids; one global advance, the last stage is the output register
  logic [NStages-1:0] vld;
  logic               en;

  assign en       = out_ready | ~vld[NStages-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NStages-2:0], in_valid};
    end
  end

  // ---- stage 1: magnitudes and 32x32 products
  logic signed [CompW-1:0] in_v [3];
  logic signed [CompW-1:0] in_n [3];
  assign in_v[0] = vel_x;
  assign in_v[1] = vel_y;
  assign in_v[2] = vel_z;
  assign in_n[0] = norm_x;
  assign in_n[1] = norm_y;
  assign in_n[2] = norm_z;

  logic signed [CompW-1:0] s1_v  [3];
  logic [CompW-1:0]        s1_nm [3];
  logic [2:0]              s1_ns;
  logic [2:0]              s1_neg;     // product sign of v_i * n_i
  logic [2*CompW-1:0]      s1_p  [3];
  logic [2*CompW-1:0]      s1_sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [CompW-1:0] vm;
        logic [CompW-1:0] nm;
        vm = in_v[i][CompW-1] ? (~in_v[i] + 1'b1) : in_v[i];
        nm = in_n[i][CompW-1] ? (~in_n[i] + 1'b1) : in_n[i];
        s1_v[i]   <= in_v[i];
        s1_nm[i]  <= nm;
        s1_ns[i]  <= in_n[i][CompW-1];
        s1_neg[i] <= in_v[i][CompW-1] ^ in_n[i][CompW-1];
        s1_p[i]   <= (2*CompW)'(vm) * (2*CompW)'(nm);
        s1_sq[i]  <= (2*CompW)'(nm) * (2*CompW)'(nm);
      end
    end
  end

  // ---- stage 2: n.n and |v.n| with its sign
  logic signed [CompW-1:0] s2_v  [3];
  logic [CompW-1:0]        s2_nm [3];
  logic [2:0]              s2_ns;
  logic [RemW-1:0]         s2_nn;
  logic [RemW-1:0]         s2_dmag;
  logic                    s2_dneg;
  logic                    s2_zero;

  logic [RemW-1:0] pos_sum, neg_sum, nn_sum;
  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    nn_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      nn_sum = nn_sum + s1_sq[i];
      if (s1_neg[i]) neg_sum = neg_sum + s1_p[i];
      else           pos_sum = pos_sum + s1_p[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v    <= s1_v;
      s2_nm   <= s1_nm;
      s2_ns   <= s1_ns;
      s2_nn   <= nn_sum;
      s2_dneg <= neg_sum > pos_sum;
      s2_dmag <= (neg_sum > pos_sum) ? (neg_sum - pos_sum) : (pos_sum - neg_sum);
      s2_zero <= (nn_sum == '0);
    end
  end

  // ---- stage 3: |d| * |n_i| as two 32x32 partial products
  logic signed [CompW-1:0] s3_v  [3];
  logic [2*CompW-1:0]      s3_lo [3];
  logic [2*CompW-1:0]      s3_hi [3];
  logic [2:0]              s3_sg;
  logic [RemW-1:0]         s3_nn;
  logic                    s3_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_lo[i] <= (2*CompW)'(s2_dmag[CompW-1:0]) * (2*CompW)'(s2_nm[i]);
        s3_hi[i] <= (2*CompW)'(s2_dmag[RemW-1:CompW]) * (2*CompW)'(s2_nm[i]);
        s3_sg[i] <= s2_dneg ^ s2_ns[i];
      end
      s3_v    <= s2_v;
      s3_nn   <= s2_nn;
      s3_zero <= s2_zero;
    end
  end

  // ---- stage 4 feeds the divider (index 0), divider stage k writes index k+1
  logic [RemW-1:0]         d_rem [0:QBits][3];
  logic [QBits-1:0]        d_low [0:QBits][3];
  logic [QBits-1:0]        d_q   [0:QBits][3];
  logic signed [CompW-1:0] d_v   [0:QBits][3];
  logic [2:0]              d_sg  [0:QBits];
  logic [RemW-1:0]         d_nn  [0:QBits];
  logic                    d_z   [0:QBits];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [NumW-1:0] num;
        num = {s3_hi[i], {CompW{1'b0}}} + NumW'(s3_lo[i]);
        d_rem[0][i] <= RemW'(num[NumW-1:QBits]);   // below n.n since q < 2^34
        d_low[0][i] <= num[QBits-1:0];
        d_q[0][i]   <= '0;
      end
      d_v[0]  <= s3_v;
      d_sg[0] <= s3_sg;
      d_nn[0] <= s3_nn;
      d_z[0]  <= s3_zero;
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_div
    div_res_t step [3];
    for (genvar i = 0; i < 3; i++) begin : g_comp
      cvr_div_step u_step (
        .rem    (d_rem[k][i]),
        .den    (d_nn[k]),
        .bit_in (d_low[k][i][QBits-1]),
        .res    (step[i])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[k+1][i] <= step[i].rem;
          d_low[k+1][i] <= {d_low[k][i][QBits-2:0], 1'b0};
          d_q[k+1][i]   <= {d_q[k][i][QBits-2:0], step[i].qbit};
        end
        d_v[k+1]  <= d_v[k];
        d_sg[k+1] <= d_sg[k];
        d_nn[k+1] <= d_nn[k];
        d_z[k+1]  <= d_z[k];
      end
    end
  end

  // ---- stage A: signed normal part and tangential part
  logic signed [35:0] sa_vn [3];
  logic signed [35:0] sa_vt [3];
  logic               sa_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [35:0] qe;
        logic signed [35:0] vn;
        qe = $signed({2'b00, d_q[QBits][i]});
        if (d_z[QBits])          vn = '0;   // zero normal: no normal part
        else if (d_sg[QBits][i]) vn = -qe;
        else                     vn = qe;
        sa_vn[i] <= vn;
        sa_vt[i] <= 36'(d_v[QBits][i]) - vn;
      end
      sa_z <= d_z[QBits];
    end
  end

  // ---- stage B: coefficient products
  logic signed [17:0] tcoef;
  logic signed [17:0] rcoef;
  assign tcoef = QOne - $signed({1'b0, friction});
  assign rcoef = $signed({1'b0, restitution});

  logic signed [53:0] sb_pt [3];
  logic signed [53:0] sb_pr [3];
  logic               sb_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sb_pt[i] <= tcoef * sa_vt[i];
        sb_pr[i] <= rcoef * sa_vn[i];
      end
      sb_z <= sa_z;
    end
  end

  // ---- stage C: blend, round half up, clamp
  logic signed [CompW-1:0] res_c [3];
  logic [2:0]              sat_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [54:0] acc;
      logic signed [38:0] r;
      acc = 55'(sb_pt[i]) - 55'(sb_pr[i]) + 55'sd32768;
      r   = acc[54:16];
      if (r > OutMax) begin
        res_c[i] = OutMax[CompW-1:0];
        sat_c[i] = 1'b1;
      end else if (r < OutMin) begin
        res_c[i] = OutMin[CompW-1:0];
        sat_c[i] = 1'b1;
      end else begin
        res_c[i] = r[CompW-1:0];
        sat_c[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x       <= res_c[0];
      out_y       <= res_c[1];
      out_z       <= res_c[2];
      zero_normal <= sb_z;
      saturated   <= |sat_c;
    end
  end

  assign out_valid = vld[NStages-1];

`ifndef SYNTHESIS
  a_ready_tracks_out : assert property (@(posedge clk) disable iff (rst)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow the output stage");

  a_reset_empties : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_sat_at_rail : assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (out_x == OutMax[CompW-1:0] || out_x == OutMin[CompW-1:0] ||
       out_y == OutMax[CompW-1:0] || out_y == OutMin[CompW-1:0] ||
       out_z == OutMax[CompW-1:0] || out_z == OutMin[CompW-1:0]))
    else $error("saturated flag without a clipped component");

  a_zero_normal_passes : assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_normal && friction == '0) |-> !saturated)
    else $error("zero normal with no friction must pass v unchanged");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_collision_velocity_response.sv =====
`default_nettype none
module tb_collision_velocity_response;
  timeunit 1ns;
  timeprecision 1ps;

  import cvr_pkg::*;

  // Unused register indexes: writes there must leave both coefficients alone.
  localparam logic [CfgIdxW-1:0] IdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] IdxSpare3 = 2'd3;
  localparam int PipeDepth   = 40;   // input transfer to result valid
  localparam int NumSettings = 8;
  localparam int RandPerSet  = 140;
  localparam int HoldCycles  = 200;  // long receiver hold-off, fills the pipe
  localparam int HoldAt      = 340;  // mid third setting, sender still streaming
  localparam longint QUnit   = 65536;

  typedef struct packed {
    logic signed [CompW-1:0] vx, vy, vz, nx, ny, nz;
  } vec_pair_t;

  typedef struct packed {
    logic signed [CompW-1:0] ox, oy, oz;
    logic                    zero;
    logic                    sat;
  } response_t;

  typedef struct packed {
    vec_pair_t item;
    logic      typed;
    response_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoefW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CompW-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [CompW-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CompW-1:0] out_x, out_y, out_z;
  logic zero_normal, saturated;

  // predictor copy of the two coefficients
  longint restit_coef = 0;
  longint frict_coef  = 0;

  response_t pending_responses[$];
  stim_row_t directed_rows[$];
  int errors = 0;
  int checked = 0;
  int zero_seen = 0;
  int sat_seen = 0;
  bit hold_done = 1'b0;
  bit sender_steady = 1'b0;  // no idle gaps on the input side while set

  always #1 clk = ~clk;

  collision_velocity_response i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .vel_x, .vel_y, .vel_z, .norm_x, .norm_y, .norm_z,
    .out_valid, .out_ready, .out_x, .out_y, .out_z, .zero_normal, .saturated
  );

  // Normal part vn = (v.n) n / (n.n), truncated toward zero; result is
  // -e*vn + (1-f)*vt rounded half up to Q16.16 and clamped.
  function automatic response_t predict_response(vec_pair_t p);
    longint v[3], n[3], vn[3];
    logic [63:0] mn[3];
    logic [63:0] nn, pos, neg, dmag, vm, q;
    logic [127:0] quo;
    logic dneg;
    longint vt, acc, r;
    logic [31:0] o[3];
    response_t res;
    v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
    n[0] = p.nx; n[1] = p.ny; n[2] = p.nz;
    nn = 0; pos = 0; neg = 0;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mn[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      vm = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      nn += mn[i] * mn[i];
      if ((v[i] < 0) != (n[i] < 0)) neg += vm * mn[i];
      else pos += vm * mn[i];
    end
    dneg = neg > pos;
    dmag = dneg ? neg - pos : pos - neg;
    res.zero = (nn == 0);
    for (int i = 0; i < 3; i++) begin
      vn[i] = 0;
      if (!res.zero) begin
        quo = ({64'b0, dmag} * {64'b0, mn[i]}) / {64'b0, nn};
        q = {30'b0, quo[33:0]};
        vn[i] = (dneg != (n[i] < 0)) ? -longint'(q) : longint'(q);
      end
      vt = v[i] - vn[i];
      acc = (QUnit - frict_coef) * vt - restit_coef * vn[i];
      r = (acc + 32768) >>> 16;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647; res.sat = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648; res.sat = 1'b1;
      end
      o[i] = r[31:0];
    end
    res.ox = o[0]; res.oy = o[1]; res.oz = o[2];
    return res;
  endfunction

  function automatic logic signed [CompW-1:0] q16(int k);
    return CompW'(k) <<< 16;
  endfunction

  // Random component: half full range, the rest small values, zero and extremes.
  function automatic logic signed [CompW-1:0] rand_comp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 32'sh7fffffff;
    if (sel < 16) return 32'sh80000000;
    if (sel < 20) return '0;
    if (sel < 50) return CompW'($signed($urandom_range(2000000)) - 1000000);
    return $urandom;
  endfunction

  function automatic vec_pair_t rand_item();
    vec_pair_t p;
    int sel;
    p.vx = rand_comp(); p.vy = rand_comp(); p.vz = rand_comp();
    p.nx = rand_comp(); p.ny = rand_comp(); p.nz = rand_comp();
    sel = $urandom_range(99);
    if (sel < 8) begin
      {p.nx, p.ny, p.nz} = '0;                       // zero normal
    end else if (sel < 16) begin
      p.nx = p.vy; p.ny = -p.vx; p.nz = '0;          // velocity along the surface
    end else if (sel < 22) begin
      p.nx = '0; p.ny = '0;                          // axis-aligned normal
    end
    return p;
  endfunction

  task automatic add_row(vec_pair_t p, logic typed, response_t want);
    stim_row_t row;
    row.item = p; row.typed = typed; row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic write_coef(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == IdxRestitution) restit_coef = val;
    else if (idx == IdxFriction) frict_coef = val;
  endtask

  // Block idle: nothing outstanding plus a full pipeline flush.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  // Offer one item and hold it until the transfer; the expectation is queued
  // at the accepting edge. valid is only lowered on an idle gap.
  task automatic send_item(vec_pair_t p, logic typed, response_t want);
    while (!sender_steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {vel_x, vel_y, vel_z, norm_x, norm_y, norm_z} <= p;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(typed ? want : predict_response(p));
  endtask

  // Result side: check each transfer against the oldest expectation.
  initial begin
    int hold_left;
    response_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = pending_responses.pop_front();
          if (out_x !== want.ox) begin
            $error("out_x: expected %0d, got %0d", want.ox, out_x); errors++;
          end
          if (out_y !== want.oy) begin
            $error("out_y: expected %0d, got %0d", want.oy, out_y); errors++;
          end
          if (out_z !== want.oz) begin
            $error("out_z: expected %0d, got %0d", want.oz, out_z); errors++;
          end
          if (zero_normal !== want.zero) begin
            $error("zero_normal: expected %0b, got %0b", want.zero, zero_normal); errors++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, saturated); errors++;
          end
          zero_seen += want.zero;
          sat_seen += want.sat;
          checked++;
          if (checked == HoldAt && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (sender_steady || $urandom_range(99) >= 21);
      end
    end
  end

  // Coefficient settings: reset values, unity, both extremes, above 1.0, random.
  logic [CoefW-1:0] set_restit[NumSettings];
  logic [CoefW-1:0] set_frict[NumSettings];

  initial begin
    response_t w;
    vec_pair_t p;
    int drain;
    set_restit = '{17'd0, 17'd65536, 17'd0, 17'd65536, 17'd131071, 17'd32768,
                   17'd0, 17'd0};
    set_frict  = '{17'd0, 17'd0, 17'd65536, 17'd65536, 17'd131071, 17'd13107,
                   17'd131071, 17'd0};
    set_restit[7] = CoefW'($urandom_range(131071));
    set_frict[7]  = CoefW'($urandom_range(131071));

    // Directed rows, all at the reset coefficients (e = 0, f = 0, out = vt).
    // Zero normal: output equals the velocity and the flag is set.
    p = '{q16(1), q16(2), q16(3), 0, 0, 0};
    add_row(p, 1'b1, '{q16(1), q16(2), q16(3), 1'b1, 1'b0});
    p = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 0, 0, 0};
    add_row(p, 1'b1, '{32'sh7fffffff, 32'sh80000000, -32'sd1, 1'b1, 1'b0});
    // Axis normals strip the normal component.
    p = '{q16(5), q16(7), q16(9), q16(1), 0, 0};
    add_row(p, 1'b1, '{0, q16(7), q16(9), 1'b0, 1'b0});
    p = '{q16(2), q16(3), q16(4), 0, q16(5), 0};
    add_row(p, 1'b1, '{q16(2), 0, q16(4), 1'b0, 1'b0});
    // Velocity along the surface passes unchanged.
    p = '{0, q16(7), q16(9), q16(1), 0, 0};
    add_row(p, 1'b1, '{0, q16(7), q16(9), 1'b0, 1'b0});
    p = '{q16(3), -q16(4), 0, 0, 0, q16(2)};
    add_row(p, 1'b1, '{q16(3), -q16(4), 0, 1'b0, 1'b0});
    w = '0;
    // Extremes and mixed vectors, predictor checked.
    add_row('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, w);
    add_row('{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, w);
    add_row('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}, 1'b0, w);
    add_row('{32'sh7fffffff, 32'sh80000000, 0, 1, 1, 1}, 1'b0, w);
    add_row('{32'sh80000000, 32'sh80000000, 32'sh80000000, -1, 0, 0}, 1'b0, w);
    add_row('{-1, -1, -1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, w);
    add_row('{32'shffffffff, 32'h55555555, 32'haaaaaaaa,
              32'h55555555, 32'haaaaaaaa, 32'shffffffff}, 1'b0, w);
    add_row('{q16(10), q16(-3), q16(6), q16(1), q16(-1), 0}, 1'b0, w);
    add_row('{0, 0, 0, q16(3), q16(4), q16(5)}, 1'b0, w);
    add_row('{q16(1), q16(1), q16(1), 1, 0, 32'sh80000000}, 1'b0, w);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int s = 0; s < NumSettings; s++) begin
      // Sender holds back until the pipeline is empty, then reprograms.
      wait_drained();
      write_coef(IdxRestitution, set_restit[s]);
      write_coef(IdxFriction, set_frict[s]);
      if (s == 1) begin
        write_coef(IdxSpare2, CoefW'($urandom));
        write_coef(IdxSpare3, CoefW'($urandom));
      end
      cfg_we <= 1'b0;
      sender_steady = (s == 2);
      if (s == 0)
        foreach (directed_rows[i])
          send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      for (int k = 0; k < RandPerSet; k++) send_item(rand_item(), 1'b0, w);
      sender_steady = 1'b0;
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_responses.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (PipeDepth + 4) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d expected results never arrived", pending_responses.size());
      errors++;
    end
    $display("checked %0d responses over %0d coefficient settings", checked, NumSettings);
    $display("zero-normal cases %0d, saturated cases %0d", zero_seen, sat_seen);
    if (errors == 0) begin
      $display("tb_collision_velocity_response passed");
    end else begin
      $display("tb_collision_velocity_response failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_collision_velocity_response failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/cvr_pkg.sv
hw/rtl/cvr_div_step.sv
hw/rtl/collision_velocity_response.sv
tb/sv/tb_collision_velocity_response.sv
